// File: rtl/core/rcfb_pkg.sv
// Package for the rectangle copy/fill blitter: frame geometry, words and store request.
package rcfb_pkg;

	localparam int FRAME_WIDTH  = 128;
	localparam int FRAME_HEIGHT = 64;
	localparam int STORE_DEPTH  = FRAME_WIDTH * FRAME_HEIGHT;
	localparam int ADDR_W       = $clog2(STORE_DEPTH);

	localparam int X_W   = 7;
	localparam int Y_W   = 6;
	localparam int PIX_W = 32;

	typedef enum logic [1:0] {
		ACT_WRITE = 2'd0,
		ACT_READ  = 2'd1,
		ACT_COPY  = 2'd2,
		ACT_FILL  = 2'd3
	} action_t;

	typedef enum logic {
		ST_DONE     = 1'b0,
		ST_REJECTED = 1'b1
	} status_t;

	typedef struct packed {
		action_t          action;
		logic [X_W-1:0]   left;
		logic [Y_W-1:0]   bottom;
		logic [X_W-1:0]   dest_left;
		logic [Y_W-1:0]   dest_bottom;
		logic [X_W-1:0]   span_x;
		logic [Y_W-1:0]   span_y;
		logic [PIX_W-1:0] pixel_value;
		logic [PIX_W-1:0] or_mask;
		logic [PIX_W-1:0] xor_mask;
	} cmd_t;

	typedef struct packed {
		logic [PIX_W-1:0] read_data;
		status_t          status;
	} rsp_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [PIX_W-1:0]  wdata;
	} mem_req_t;

endpackage

// File: rtl/core/rcfb_frame_store.sv
// Single-port frame store with registered read data.
module rcfb_frame_store (
	input  logic                          clk,
	input  rcfb_pkg::mem_req_t            req,
	output logic [rcfb_pkg::PIX_W-1:0]    rdata
);

	logic [rcfb_pkg::PIX_W-1:0] mem_q [rcfb_pkg::STORE_DEPTH];

	// Write when asked; read every cycle at the same address.
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.addr] <= req.wdata;
		end
		rdata <= mem_q[req.addr];
	end

endmodule

// File: rtl/core/rect_copy_fill_blitter.sv
// Top level of the rectangle copy/fill blitter: sequencer, bounds check and address unit.
// Sequence: a word is taken at a clock edge with start high and busy low; it then passes
// S_CHECK, where a rejected word strobes done; a pixel write goes on to S_WRITE, a pixel read
// to S_READ and S_RDDONE, and a copy or fill alternates S_READ and S_WRITE for each pixel
// of the rectangle, done strobing after the last write. The single store port is the limit:
// each pixel takes a read state and a write state. One word is worked at a time; busy stays
// high until its result is out.
// Reset (arst_n low) returns the sequencer to idle; the frame store holds no reset value.
module rect_copy_fill_blitter (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  rcfb_pkg::cmd_t   cmd,
	output logic             busy,
	output logic             done,
	output rcfb_pkg::rsp_t   result
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_READ,
		S_WRITE,
		S_RDDONE
	} state_t;

	state_t                        state_q;
	rcfb_pkg::cmd_t                cmd_q;
	logic [rcfb_pkg::X_W-1:0]      xo_q;     // column offset within the rectangle
	logic [rcfb_pkg::Y_W-1:0]      yo_q;     // row offset within the rectangle
	logic                          x_dec_q;  // walk right to left
	logic                          y_dec_q;  // walk top row first
	logic                          done_q;
	rcfb_pkg::rsp_t                result_q;

	rcfb_pkg::mem_req_t            mem_req;
	logic [rcfb_pkg::PIX_W-1:0]    mem_rdata;

	logic                          src_ok;
	logic                          dst_ok;
	logic                          rect_ok;
	logic                          use_dest;
	logic [rcfb_pkg::X_W-1:0]      base_x;
	logic [rcfb_pkg::Y_W-1:0]      base_y;
	logic [rcfb_pkg::X_W-1:0]      pix_x;
	logic [rcfb_pkg::Y_W-1:0]      pix_y;
	logic [rcfb_pkg::X_W-1:0]      x_end;
	logic [rcfb_pkg::Y_W-1:0]      y_end;
	logic                          row_last;
	logic                          col_last;
	logic [rcfb_pkg::PIX_W-1:0]    wr_word;

	// Bounds check. Pixel actions use zero spans, so only the corner is tested.
	always_comb begin
		logic [rcfb_pkg::X_W:0] sx;
		logic [rcfb_pkg::Y_W:0] sy;
		logic [rcfb_pkg::X_W:0] sum_sx;
		logic [rcfb_pkg::Y_W:0] sum_sy;
		logic [rcfb_pkg::X_W:0] sum_dx;
		logic [rcfb_pkg::Y_W:0] sum_dy;
		sx = '0;
		sy = '0;
		if (cmd_q.action == rcfb_pkg::ACT_COPY || cmd_q.action == rcfb_pkg::ACT_FILL) begin
			sx = {1'b0, cmd_q.span_x};
			sy = {1'b0, cmd_q.span_y};
		end
		sum_sx = {1'b0, cmd_q.left} + sx;
		sum_sy = {1'b0, cmd_q.bottom} + sy;
		sum_dx = {1'b0, cmd_q.dest_left} + sx;
		sum_dy = {1'b0, cmd_q.dest_bottom} + sy;
		src_ok = (32'(sum_sx) < 32'(rcfb_pkg::FRAME_WIDTH))
			&& (32'(sum_sy) < 32'(rcfb_pkg::FRAME_HEIGHT));
		dst_ok = (32'(sum_dx) < 32'(rcfb_pkg::FRAME_WIDTH))
			&& (32'(sum_dy) < 32'(rcfb_pkg::FRAME_HEIGHT));
		rect_ok = src_ok && ((cmd_q.action != rcfb_pkg::ACT_COPY) || dst_ok);
	end

	// Shared address unit: source corner while reading, destination corner while
	// writing a copy. Rows are stored top first, so flip y before scaling by the width.
	assign use_dest = (state_q == S_WRITE) && (cmd_q.action == rcfb_pkg::ACT_COPY);
	assign base_x   = use_dest ? cmd_q.dest_left   : cmd_q.left;
	assign base_y   = use_dest ? cmd_q.dest_bottom : cmd_q.bottom;
	assign pix_x    = base_x + xo_q;
	assign pix_y    = base_y + yo_q;

	// Walk end points and the last-pixel test.
	assign x_end    = x_dec_q ? '0 : cmd_q.span_x;
	assign y_end    = y_dec_q ? '0 : cmd_q.span_y;
	assign col_last = (xo_q == x_end);
	assign row_last = (yo_q == y_end);

	// Data for the write cycle: the word for a pixel write, the fetched pixel for a
	// copy, or the fetched pixel through the OR/XOR masks for a fill.
	always_comb begin
		case (cmd_q.action)
			rcfb_pkg::ACT_WRITE: wr_word = cmd_q.pixel_value;
			rcfb_pkg::ACT_FILL:  wr_word = (mem_rdata | cmd_q.or_mask) ^ cmd_q.xor_mask;
			default:             wr_word = mem_rdata;
		endcase
	end

	always_comb begin
		mem_req.we    = (state_q == S_WRITE);
		mem_req.addr  = rcfb_pkg::ADDR_W'((rcfb_pkg::FRAME_HEIGHT - 1 - int'(pix_y))
			* rcfb_pkg::FRAME_WIDTH + int'(pix_x));
		mem_req.wdata = wr_word;
	end

	rcfb_frame_store u_store (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

	// Sequencer: check, then for a copy or fill one read and one write per pixel until the walk ends.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			done_q   <= 1'b0;
			result_q <= '0;
			cmd_q    <= '0;
			xo_q     <= '0;
			yo_q     <= '0;
			x_dec_q  <= 1'b0;
			y_dec_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					// Take the next word.
					if (start) begin
						cmd_q   <= cmd;
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (!rect_ok) begin
						// Drop the word; the store stays untouched.
						done_q             <= 1'b1;
						result_q.read_data <= '0;
						result_q.status    <= rcfb_pkg::ST_REJECTED;
						state_q            <= S_IDLE;
					end else begin
						// Pick the overlap-safe walk order for a copy; any other action
						// walks forward.
						if (cmd_q.action == rcfb_pkg::ACT_COPY) begin
							x_dec_q <= (cmd_q.left < cmd_q.dest_left);
							y_dec_q <= (cmd_q.bottom < cmd_q.dest_bottom);
							xo_q    <= (cmd_q.left < cmd_q.dest_left) ? cmd_q.span_x : '0;
							yo_q    <= (cmd_q.bottom < cmd_q.dest_bottom) ? cmd_q.span_y : '0;
						end else begin
							x_dec_q <= 1'b0;
							y_dec_q <= 1'b0;
							xo_q    <= '0;
							yo_q    <= '0;
						end
						if (cmd_q.action == rcfb_pkg::ACT_WRITE) begin
							state_q <= S_WRITE;
						end else begin
							state_q <= S_READ;
						end
					end
				end
				S_READ: begin
					// Read data lands in the store's output register next cycle.
					if (cmd_q.action == rcfb_pkg::ACT_READ) begin
						state_q <= S_RDDONE;
					end else begin
						state_q <= S_WRITE;
					end
				end
				S_RDDONE: begin
					done_q             <= 1'b1;
					result_q.read_data <= mem_rdata;
					result_q.status    <= rcfb_pkg::ST_DONE;
					state_q            <= S_IDLE;
				end
				S_WRITE: begin
					if (cmd_q.action == rcfb_pkg::ACT_WRITE || (col_last && row_last)) begin
						done_q             <= 1'b1;
						result_q.read_data <= '0;
						result_q.status    <= rcfb_pkg::ST_DONE;
						state_q            <= S_IDLE;
					end else begin
						// Advance along the row, or wrap to the next row.
						if (col_last) begin
							xo_q <= x_dec_q ? cmd_q.span_x : '0;
							yo_q <= y_dec_q ? (yo_q - 1'b1) : (yo_q + 1'b1);
						end else begin
							xo_q <= x_dec_q ? (xo_q - 1'b1) : (xo_q + 1'b1);
						end
						state_q <= S_READ;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

// File: bench/rect_copy_fill_blitter_tb.sv
// Self-checking testbench for the rectangle copy/fill blitter: directed table, then random words.
`timescale 1ns / 100ps

module rect_copy_fill_blitter_tb;

	localparam int CLK_PERIOD   = 10;
	localparam int RESET_CYCLES = 12;
	localparam int RANDOM_WORDS = 75;
	// Words near the end go in back to back, with no sender gaps.
	localparam int TAIL_WORDS   = 20;
	// Allow every word to be as slow as a full-frame copy or fill,
	// plus the longest sender gap, then several times over.
	localparam int CYCLE_LIMIT  = 8_000_000;

	typedef struct {
		rcfb_pkg::cmd_t w;
		bit             known;
		rcfb_pkg::rsp_t want;
	} plan_row_t;

	logic           clk    = 1'b0;
	logic           arst_n = 1'b0;
	logic           start  = 1'b0;
	rcfb_pkg::cmd_t cmd    = '0;
	logic           busy;
	logic           done;
	rcfb_pkg::rsp_t result;

	// Shadow copy of the frame store, indexed [y][x] with y counting up from the bottom.
	logic [rcfb_pkg::PIX_W-1:0] shadow_px [rcfb_pkg::FRAME_HEIGHT][rcfb_pkg::FRAME_WIDTH];
	// Snapshot of a copy source, so overlapping copies behave like memmove.
	logic [rcfb_pkg::PIX_W-1:0] copy_buf [rcfb_pkg::FRAME_HEIGHT][rcfb_pkg::FRAME_WIDTH];

	rcfb_pkg::rsp_t pending_results[$];
	plan_row_t      directed_rows[$];
	int             mismatch_count = 0;
	int             cycle_count    = 0;

	rect_copy_fill_blitter i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Hard stop: a hung sequencer never returns done.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic flag_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		mismatch_count++;
	endtask

	function automatic bit fits(input int l, input int b, input int sx, input int sy);
		return (l + sx) < rcfb_pkg::FRAME_WIDTH && (b + sy) < rcfb_pkg::FRAME_HEIGHT;
	endfunction

	// Apply one word to the shadow frame and return the result it should produce.
	function automatic rcfb_pkg::rsp_t blit_step(input rcfb_pkg::cmd_t w);
		rcfb_pkg::rsp_t r;
		int             l, b, dl, db, sx, sy;
		r.read_data = '0;
		r.status    = rcfb_pkg::ST_DONE;
		l  = int'(w.left);
		b  = int'(w.bottom);
		dl = int'(w.dest_left);
		db = int'(w.dest_bottom);
		sx = int'(w.span_x);
		sy = int'(w.span_y);
		case (w.action)
		rcfb_pkg::ACT_WRITE: begin
			if (fits(l, b, 0, 0))
				shadow_px[b][l] = w.pixel_value;
			else
				r.status = rcfb_pkg::ST_REJECTED;
		end
		rcfb_pkg::ACT_READ: begin
			if (fits(l, b, 0, 0))
				r.read_data = shadow_px[b][l];
			else
				r.status = rcfb_pkg::ST_REJECTED;
		end
		rcfb_pkg::ACT_COPY: begin
			if (fits(l, b, sx, sy) && fits(dl, db, sx, sy)) begin
				// Take the whole source first; the walk order only exists to get this effect.
				for (int y = 0; y <= sy; y++)
					for (int x = 0; x <= sx; x++)
						copy_buf[y][x] = shadow_px[b + y][l + x];
				for (int y = 0; y <= sy; y++)
					for (int x = 0; x <= sx; x++)
						shadow_px[db + y][dl + x] = copy_buf[y][x];
			end else begin
				r.status = rcfb_pkg::ST_REJECTED;
			end
		end
		default: begin
			if (fits(l, b, sx, sy)) begin
				for (int y = b; y <= b + sy; y++)
					for (int x = l; x <= l + sx; x++)
						shadow_px[y][x] = (shadow_px[y][x] | w.or_mask) ^ w.xor_mask;
			end else begin
				r.status = rcfb_pkg::ST_REJECTED;
			end
		end
		endcase
		return r;
	endfunction

	function automatic rcfb_pkg::cmd_t word_of(input rcfb_pkg::action_t a, input int l,
			input int b, input int dl, input int db, input int sx, input int sy,
			input logic [rcfb_pkg::PIX_W-1:0] pv, input logic [rcfb_pkg::PIX_W-1:0] om,
			input logic [rcfb_pkg::PIX_W-1:0] em);
		rcfb_pkg::cmd_t w;
		w.action      = a;
		w.left        = rcfb_pkg::X_W'(l);
		w.bottom      = rcfb_pkg::Y_W'(b);
		w.dest_left   = rcfb_pkg::X_W'(dl);
		w.dest_bottom = rcfb_pkg::Y_W'(db);
		w.span_x      = rcfb_pkg::X_W'(sx);
		w.span_y      = rcfb_pkg::Y_W'(sy);
		w.pixel_value = pv;
		w.or_mask     = om;
		w.xor_mask    = em;
		return w;
	endfunction

	task automatic add_row(input rcfb_pkg::cmd_t w, input bit known,
			input logic [rcfb_pkg::PIX_W-1:0] rd, input rcfb_pkg::status_t st);
		plan_row_t row;
		row.w              = w;
		row.known          = known;
		row.want.read_data = rd;
		row.want.status    = st;
		directed_rows.push_back(row);
	endtask

	// Mostly well-formed rectangles of small size, now and then a large one,
	// often overlapping copies; one word in eight is raw noise.
	function automatic rcfb_pkg::cmd_t pick_word();
		rcfb_pkg::cmd_t w;
		int             kind, sx, sy, l, b, dl, db;
		w.left        = rcfb_pkg::X_W'($urandom);
		w.bottom      = rcfb_pkg::Y_W'($urandom);
		w.dest_left   = rcfb_pkg::X_W'($urandom);
		w.dest_bottom = rcfb_pkg::Y_W'($urandom);
		w.span_x      = rcfb_pkg::X_W'($urandom);
		w.span_y      = rcfb_pkg::Y_W'($urandom);
		w.pixel_value = $urandom;
		w.or_mask     = $urandom;
		w.xor_mask    = $urandom;
		kind = $urandom_range(0, 9);
		w.action = kind < 3 ? rcfb_pkg::ACT_WRITE : kind < 5 ? rcfb_pkg::ACT_READ
			: kind < 7 ? rcfb_pkg::ACT_COPY : rcfb_pkg::ACT_FILL;
		if ($urandom_range(0, 7) == 0)
			return w;
		sx = ($urandom_range(0, 15) == 0) ? $urandom_range(0, rcfb_pkg::FRAME_WIDTH - 1)
			: $urandom_range(0, 7);
		sy = ($urandom_range(0, 15) == 0) ? $urandom_range(0, rcfb_pkg::FRAME_HEIGHT - 1)
			: $urandom_range(0, 7);
		l = $urandom_range(0, rcfb_pkg::FRAME_WIDTH - 1 - sx);
		b = $urandom_range(0, rcfb_pkg::FRAME_HEIGHT - 1 - sy);
		if ($urandom_range(0, 2) == 0) begin
			// Shift the destination a few pixels off the source, clamped into the frame.
			dl = l + int'($urandom_range(0, 6)) - 3;
			db = b + int'($urandom_range(0, 6)) - 3;
			if (dl < 0) dl = 0;
			if (db < 0) db = 0;
			if (dl > rcfb_pkg::FRAME_WIDTH - 1 - sx) dl = rcfb_pkg::FRAME_WIDTH - 1 - sx;
			if (db > rcfb_pkg::FRAME_HEIGHT - 1 - sy) db = rcfb_pkg::FRAME_HEIGHT - 1 - sy;
		end else begin
			dl = $urandom_range(0, rcfb_pkg::FRAME_WIDTH - 1 - sx);
			db = $urandom_range(0, rcfb_pkg::FRAME_HEIGHT - 1 - sy);
		end
		case ($urandom_range(0, 3))
		0: w.or_mask = '1;
		1: w.or_mask = '0;
		default: ;
		endcase
		w.left        = rcfb_pkg::X_W'(l);
		w.bottom      = rcfb_pkg::Y_W'(b);
		w.dest_left   = rcfb_pkg::X_W'(dl);
		w.dest_bottom = rcfb_pkg::Y_W'(db);
		w.span_x      = rcfb_pkg::X_W'(sx);
		w.span_y      = rcfb_pkg::Y_W'(sy);
		return w;
	endfunction

	// Now and then hold start low for a random burst. When it does, it waits on the clock, so the
	// next raise of start lands in a later time step than this drop.
	task automatic maybe_idle(input bit allow);
		if (allow && $urandom_range(0, 2) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
	endtask

	// Present a word and hold it until the block takes it, then log what it owes us.
	task automatic send_word(input rcfb_pkg::cmd_t w, input bit known,
			input rcfb_pkg::rsp_t want);
		rcfb_pkg::rsp_t predicted;
		cmd <= w;
		if (!start)
			start <= 1'b1;
		do @(posedge clk); while (busy);
		predicted = blit_step(w);
		pending_results.push_back(known ? want : predicted);
	endtask

	// Check every strobed result against the oldest word still owed.
	always @(posedge clk) begin : check_results
		rcfb_pkg::rsp_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				flag_mismatch($sformatf("result %h with no word outstanding", result));
			end else begin
				want = pending_results.pop_front();
				if (result.read_data !== want.read_data)
					flag_mismatch($sformatf("read_data got %h want %h",
						result.read_data, want.read_data));
				if (result.status !== want.status)
					flag_mismatch($sformatf("status got %0d want %0d",
						result.status, want.status));
			end
		end
	end

	initial begin
		// Rectangles that leave the frame; the store is still blank, but nothing is read.
		add_row(word_of(rcfb_pkg::ACT_FILL, 127, 0, 0, 0, 1, 0, '0, '0, '0),
			1'b1, '0, rcfb_pkg::ST_REJECTED);
		add_row(word_of(rcfb_pkg::ACT_COPY, 0, 0, 0, 63, 0, 1, '0, '0, '0),
			1'b1, '0, rcfb_pkg::ST_REJECTED);
		add_row(word_of(rcfb_pkg::ACT_COPY, 127, 63, 127, 63, 127, 63, '1, '1, '1),
			1'b1, '0, rcfb_pkg::ST_REJECTED);
		// Corner pixel, all ones in and out.
		add_row(word_of(rcfb_pkg::ACT_WRITE, 0, 0, 0, 0, 0, 0, '1, '0, '0),
			1'b1, '0, rcfb_pkg::ST_DONE);
		add_row(word_of(rcfb_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, '0, '0, '0),
			1'b1, '1, rcfb_pkg::ST_DONE);
		// Seed the rest of the bottom-left run of four pixels.
		add_row(word_of(rcfb_pkg::ACT_WRITE, 1, 0, 0, 0, 0, 0, '0, '0, '0),
			1'b1, '0, rcfb_pkg::ST_DONE);
		add_row(word_of(rcfb_pkg::ACT_WRITE, 2, 0, 0, 0, 0, 0, 32'h5A5A_A5A5, '0, '0),
			1'b1, '0, rcfb_pkg::ST_DONE);
		add_row(word_of(rcfb_pkg::ACT_WRITE, 3, 0, 0, 0, 0, 0, 32'h0123_4567, '0, '0),
			1'b1, '0, rcfb_pkg::ST_DONE);
		// Double the written area by copies until the whole frame holds known data:
		// first across the bottom row, then up the frame.
		for (int s = 4; s < rcfb_pkg::FRAME_WIDTH; s *= 2)
			add_row(word_of(rcfb_pkg::ACT_COPY, 0, 0, s, 0, s - 1, 0, '0, '0, '0),
				1'b0, '0, rcfb_pkg::ST_DONE);
		for (int s = 1; s < rcfb_pkg::FRAME_HEIGHT; s *= 2)
			add_row(word_of(rcfb_pkg::ACT_COPY, 0, 0, 0, s, rcfb_pkg::FRAME_WIDTH - 1, s - 1,
				'0, '0, '0), 1'b0, '0, rcfb_pkg::ST_DONE);
		// Full-frame fill.
		add_row(word_of(rcfb_pkg::ACT_FILL, 0, 0, 0, 0, 127, 63, '0, 32'h0000_FFFF,
			32'hA5A5_A5A5), 1'b0, '0, rcfb_pkg::ST_DONE);
		// Overlapping copies: source below-left of destination, then the reverse.
		add_row(word_of(rcfb_pkg::ACT_COPY, 10, 10, 12, 11, 9, 9, '0, '0, '0),
			1'b0, '0, rcfb_pkg::ST_DONE);
		add_row(word_of(rcfb_pkg::ACT_COPY, 12, 11, 10, 10, 9, 9, '0, '0, '0),
			1'b0, '0, rcfb_pkg::ST_DONE);
		// Solid fill: an all-ones OR mask leaves the inverse of the XOR mask.
		add_row(word_of(rcfb_pkg::ACT_FILL, 5, 5, 0, 0, 3, 3, '0, '1, 32'h1234_5678),
			1'b0, '0, rcfb_pkg::ST_DONE);
		add_row(word_of(rcfb_pkg::ACT_READ, 6, 7, 0, 0, 0, 0, '0, '0, '0),
			1'b1, 32'hEDCB_A987, rcfb_pkg::ST_DONE);
		// Full-frame copy onto itself.
		add_row(word_of(rcfb_pkg::ACT_COPY, 0, 0, 0, 0, 127, 63, '0, '0, '0),
			1'b0, '0, rcfb_pkg::ST_DONE);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			maybe_idle(1'b1);
			send_word(directed_rows[i].w, directed_rows[i].known, directed_rows[i].want);
		end

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (i == RANDOM_WORDS / 2) begin
				// Drain: hold off until the block has answered every word.
				start <= 1'b0;
				do @(posedge clk); while (pending_results.size() != 0);
			end else begin
				maybe_idle(i < RANDOM_WORDS - TAIL_WORDS);
			end
			send_word(pick_word(), 1'b0, '0);
		end
		start <= 1'b0;

		// Wait out the last result, then a few cycles for any stray strobe.
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// File: sim.f
rtl/core/rcfb_pkg.sv
rtl/core/rcfb_frame_store.sv
rtl/core/rect_copy_fill_blitter.sv
bench/rect_copy_fill_blitter_tb.sv
